// ===== sv/psd_pkg.sv =====
package psd_pkg;

    // decoder phases, one-hot
    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_PALETTE = 5'b00010,
        PH_PIXELS  = 5'b00100,
        PH_DONE    = 5'b01000,
        PH_ERROR   = 5'b10000
    } phase_t;

    // result kinds
    localparam logic [1:0] KIND_HEADER   = 2'd0;
    localparam logic [1:0] KIND_PIXEL    = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;
    localparam logic [1:0] KIND_COMPLETE = 2'd3;

    // error codes
    localparam logic [1:0] ERR_MAGIC     = 2'd0;
    localparam logic [1:0] ERR_ZERO_SIZE = 2'd1;
    localparam logic [1:0] ERR_PAL_TYPE  = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED = 2'd3;

    // header constants
    localparam logic [7:0] MAGIC_0 = 8'h52; // R
    localparam logic [7:0] MAGIC_1 = 8'h49; // I
    localparam logic [7:0] MAGIC_2 = 8'h58; // X
    localparam logic [7:0] MAGIC_3 = 8'h33; // 3
    localparam logic [7:0] PAL_TYPE_EGA = 8'hCB;
    localparam logic [7:0] PAL_TYPE_VGA = 8'hAF;
    localparam logic [3:0] HEADER_LAST  = 4'd9;
    localparam logic [7:0] EGA_LAST_ENTRY = 8'd15;
    localparam logic [7:0] VGA_LAST_ENTRY = 8'd255;
    localparam logic [7:0] EGA_ENTRIES    = 8'd16;
    localparam logic [5:0] VGA_MAX        = 6'd63;
    localparam logic [1:0] COMP_R = 2'd0;
    localparam logic [1:0] COMP_G = 2'd1;
    localparam logic [1:0] COMP_B = 2'd2;

    // result travelling from the parser to the colour stage
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] column;
        logic [15:0] row;
        logic        color_valid;
        logic [1:0]  error_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        last;
        logic        vga;
    } res_t;

    // scale one component to 0..255: c*255/max, saturating above max
    function automatic logic [7:0] scale_comp(input logic [7:0] c, input logic vga);
        logic [7:0] q;
        begin
            q = 8'd0;
            if (vga) begin
                if (c > 8'(VGA_MAX)) begin
                    q = 8'd255;
                end else begin
                    // c*255/63 = 4c + c/21 for c up to 63
                    q = {c[5:0], 2'b00};
                    if (c == 8'(VGA_MAX)) begin
                        q = q + 8'd3;
                    end else if (c >= 8'd42) begin
                        q = q + 8'd2;
                    end else if (c >= 8'd21) begin
                        q = q + 8'd1;
                    end
                end
            end else begin
                if (c > 8'd3) begin
                    q = 8'd255;
                end else begin
                    q = {c[1:0], c[1:0], c[1:0], c[1:0]}; // c*85
                end
            end
            return q;
        end
    endfunction

endpackage

// ===== sv/psd_ram.sv =====
module psd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port; read data holds without re
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/psd_parse.sv =====
module psd_parse #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               accept,
    input  logic [7:0]                         byte_value,
    input  logic                               stream_end,
    output logic                               res_valid,
    output psd_pkg::res_t                      res,
    output logic                               ram_we,
    output logic [$clog2(PALETTE_ENTRIES)-1:0] ram_waddr,
    output logic [23:0]                        ram_wdata,
    output logic                               ram_re,
    output logic [$clog2(PALETTE_ENTRIES)-1:0] ram_raddr
);
    import psd_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

    phase_t      phase_reg, phase_next;
    logic [3:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [1:0]  comp_reg, comp_next;
    logic [7:0]  entry_reg, entry_next;
    logic        vga_reg, vga_next;
    logic [7:0]  part_r_reg, part_r_next;
    logic [7:0]  part_g_reg, part_g_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [7:0]  hdr_reg [9];

    logic [15:0] hdr_width, hdr_height;
    logic [16:0] col_inc, row_inc;
    logic        idx_ok, is_last;

    assign hdr_width  = {hdr_reg[5], hdr_reg[4]};
    assign hdr_height = {hdr_reg[7], hdr_reg[6]};
    assign col_inc    = {1'b0, col_reg} + 17'd1;
    assign row_inc    = {1'b0, row_reg} + 17'd1;
    assign is_last    = (col_inc >= {1'b0, width_reg}) && (row_inc >= {1'b0, height_reg});
    assign idx_ok     = ({1'b0, byte_value} < PAL_LIMIT) &&
                        (vga_reg || (byte_value < EGA_ENTRIES));

    // palette loading and pixel reads
    assign ram_we    = accept && !stream_end && (phase_reg == PH_PALETTE) &&
                       (comp_reg == COMP_B) && ({1'b0, entry_reg} < PAL_LIMIT);
    assign ram_waddr = entry_reg[AW-1:0];
    assign ram_wdata = {part_r_reg, part_g_reg, byte_value};
    assign ram_re    = accept && !stream_end && (phase_reg == PH_PIXELS) && idx_ok;
    assign ram_raddr = byte_value[AW-1:0];

    // next state and result for one accepted beat
    always_comb begin
        phase_next  = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        comp_next   = comp_reg;
        entry_next  = entry_reg;
        vga_next    = vga_reg;
        part_r_next = part_r_reg;
        part_g_next = part_g_reg;
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (accept) begin
            if (stream_end) begin
                // rearm
                phase_next   = PH_HEADER;
                hdr_cnt_next = 4'd0;
                comp_next    = COMP_R;
                entry_next   = 8'd0;
                part_r_next  = 8'd0;
                part_g_next  = 8'd0;
                col_next     = 16'd0;
                row_next     = 16'd0;
                if (phase_reg == PH_DONE) begin
                    res_valid = 1'b1;
                    res.kind  = KIND_COMPLETE;
                end else if (phase_reg != PH_ERROR) begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_TRUNCATED;
                end
            end else begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        if (hdr_cnt_reg != HEADER_LAST) begin
                            hdr_cnt_next = hdr_cnt_reg + 4'd1;
                        end else begin
                            hdr_cnt_next = 4'd0;
                            res_valid    = 1'b1;
                            if (hdr_reg[0] != MAGIC_0 || hdr_reg[1] != MAGIC_1 ||
                                hdr_reg[2] != MAGIC_2 || hdr_reg[3] != MAGIC_3) begin
                                phase_next     = PH_ERROR;
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_MAGIC;
                            end else begin
                                width_next  = hdr_width;
                                height_next = hdr_height;
                                if (hdr_width == 16'd0 || hdr_height == 16'd0) begin
                                    phase_next     = PH_ERROR;
                                    res.kind       = KIND_ERROR;
                                    res.error_code = ERR_ZERO_SIZE;
                                end else if (hdr_reg[8] == PAL_TYPE_EGA ||
                                             hdr_reg[8] == PAL_TYPE_VGA) begin
                                    vga_next         = (hdr_reg[8] == PAL_TYPE_VGA);
                                    phase_next       = PH_PALETTE;
                                    comp_next        = COMP_R;
                                    entry_next       = 8'd0;
                                    res.kind         = KIND_HEADER;
                                    res.image_width  = hdr_width;
                                    res.image_height = hdr_height;
                                end else begin
                                    phase_next     = PH_ERROR;
                                    res.kind       = KIND_ERROR;
                                    res.error_code = ERR_PAL_TYPE;
                                end
                            end
                        end
                    end
                    PH_PALETTE: begin
                        case (comp_reg)
                            COMP_R: begin
                                part_r_next = byte_value;
                                part_g_next = 8'd0;
                                comp_next   = COMP_G;
                            end
                            COMP_G: begin
                                part_g_next = byte_value;
                                comp_next   = COMP_B;
                            end
                            default: begin
                                comp_next = COMP_R;
                                if (entry_reg == (vga_reg ? VGA_LAST_ENTRY : EGA_LAST_ENTRY))
                                begin
                                    entry_next = 8'd0;
                                    phase_next = PH_PIXELS;
                                end else begin
                                    entry_next = entry_reg + 8'd1;
                                end
                            end
                        endcase
                    end
                    PH_PIXELS: begin
                        res_valid       = 1'b1;
                        res.kind        = KIND_PIXEL;
                        res.column      = col_reg;
                        res.row         = row_reg;
                        res.color_valid = idx_ok;
                        res.last        = is_last;
                        res.vga         = vga_reg;
                        if (is_last) begin
                            phase_next = PH_DONE;
                        end else if (col_inc >= {1'b0, width_reg}) begin
                            col_next = 16'd0;
                            row_next = row_inc[15:0];
                        end else begin
                            col_next = col_inc[15:0];
                        end
                    end
                    PH_DONE, PH_ERROR: begin
                        // bytes dropped
                    end
                    default: begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            hdr_cnt_reg <= 4'd0;
            comp_reg    <= COMP_R;
            entry_reg   <= 8'd0;
            vga_reg     <= 1'b0;
            part_r_reg  <= 8'd0;
            part_g_reg  <= 8'd0;
            width_reg   <= 16'd0;
            height_reg  <= 16'd0;
            col_reg     <= 16'd0;
            row_reg     <= 16'd0;
        end else begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            comp_reg    <= comp_next;
            entry_reg   <= entry_next;
            vga_reg     <= vga_next;
            part_r_reg  <= part_r_next;
            part_g_reg  <= part_g_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    // header bytes, spare byte not kept
    always_ff @(posedge aclk) begin
        if (accept && !stream_end && phase_reg == PH_HEADER && hdr_cnt_reg != HEADER_LAST) begin
            hdr_reg[hdr_cnt_reg] <= byte_value;
        end
    end

endmodule

// ===== sv/psd_out.sv =====
module psd_out (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          res_valid,
    input  psd_pkg::res_t res,
    input  logic [23:0]   ram_rdata,
    output logic          ready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);
    import psd_pkg::*;

    logic  s1_valid_reg, s1_valid_next;
    res_t  s1_reg;
    logic  m_valid_reg, m_valid_next;
    logic  out_free, s1_move, colour_on;
    logic [7:0]  red, green, blue;
    logic [95:0] m_data_reg;
    logic [1:0]  m_kind_reg;
    logic        m_last_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign ready    = !s1_valid_reg || out_free;

    assign s1_valid_next = res_valid || (s1_valid_reg && !out_free);
    assign m_valid_next  = s1_move || (m_valid_reg && !m_tready);

    // scaling of the palette entry read when this result was taken
    assign colour_on = (s1_reg.kind == KIND_PIXEL) && s1_reg.color_valid;
    assign red   = colour_on ? scale_comp(ram_rdata[23:16], s1_reg.vga) : 8'd0;
    assign green = colour_on ? scale_comp(ram_rdata[15:8],  s1_reg.vga) : 8'd0;
    assign blue  = colour_on ? scale_comp(ram_rdata[7:0],   s1_reg.vga) : 8'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            s1_reg <= res;
        end
        if (s1_move) begin
            m_data_reg <= {5'd0, s1_reg.image_height, s1_reg.image_width, s1_reg.error_code,
                           s1_reg.color_valid, s1_reg.row, s1_reg.column,
                           blue, green, red};
            m_kind_reg <= s1_reg.kind;
            m_last_reg <= s1_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== sv/palette_image_stream_decoder_core.sv =====
// Channel | Dir | tdata (lowest bit up)                        | tuser       | tlast
// s_      | in  | byte_value[7:0]                              | -           | stream_end
// m_      | out | red, green, blue, column, row, color_valid,  | result_kind | last
//         |     | error_code, image_width, image_height, pad   |             |
//
// One byte is taken every cycle while m_ is not stalled; its result then reaches m_ in order:
// parser and palette read at the accepting edge, colour scaling into the output register next.
// The palette memory is read at most once per pixel byte and written at most once per palette entry.
// Reset clears the parser state; the palette memory is not cleared.
// A stalled m_ side holds the pipeline; s_tready drops only once both stages are full.
module palette_image_stream_decoder_core #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // byte_value[7:0]
    input  logic        s_tlast,  // stream_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,  // red[7:0], green[15:8], blue[23:16], column[39:24],
                                  // row[55:40], color_valid[56], error_code[58:57],
                                  // image_width[74:59], image_height[90:75], zero[95:91]
    output logic [1:0]  m_tuser,  // result_kind[1:0]
    output logic        m_tlast   // last
);
    import psd_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic          accept;
    logic          res_valid;
    res_t          res;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [23:0]   ram_wdata, ram_rdata;

    assign accept = s_tvalid && s_tready;

    psd_parse #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .byte_value (s_tdata),
        .stream_end (s_tlast),
        .res_valid  (res_valid),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr)
    );

    psd_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_palette (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    psd_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .ram_rdata (ram_rdata),
        .ready     (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
